FILE: rtl/cf2a_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cf2a_pkg
// Types, constants and helpers shared by the CAN frame to ASCII hex encoder.
// ----------------------------------------------------------------------------
package cf2a_pkg;

  localparam int unsigned MAX_PAYLOAD_BYTES_DEF = 8;
  localparam int unsigned EXT_ID_DIGITS         = 8;
  localparam int unsigned STD_ID_DIGITS         = 3;

  localparam logic [7:0] TERMINATOR_RESET = 8'h0D;
  localparam logic [7:0] CHAR_EXT_HEADER  = 8'h52;
  localparam logic [7:0] CHAR_STD_HEADER  = 8'h72;

  typedef struct packed {
    logic        is_extended;
    logic [28:0] can_id;
    logic [7:0]  filter_index;
    logic [3:0]  data_length;
    logic [63:0] payload;
  } frame_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } text_t;

  // Lower-case hex digit for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] code;
    if (nib < 4'd10) begin
      code = 8'h30 + {4'h0, nib};
    end else begin
      code = 8'h57 + {4'h0, nib};
    end
    return code;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cf2a_char_sel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cf2a_char_sel
// Picks the character at a given position of the text form of one frame.
// ----------------------------------------------------------------------------
module cf2a_char_sel #(
  parameter int unsigned MAX_PAYLOAD_BYTES = cf2a_pkg::MAX_PAYLOAD_BYTES_DEF,
  parameter int unsigned IDX_W             = 5
) (
  input  cf2a_pkg::frame_t   frame,
  input  logic [IDX_W-1:0]   char_idx,
  input  logic [7:0]         terminator,
  output cf2a_pkg::text_t    sel_item
);

  always_comb begin
    logic [IDX_W-1:0] id_end;
    logic [IDX_W-1:0] off;
    logic [IDX_W-1:0] k;
    logic [IDX_W-1:0] pay_chars;
    logic [3:0]       nbytes;
    logic [2:0]       nib_pos;
    logic [31:0]      id_ext;
    logic [3:0]       pay_nib;

    id_end  = frame.is_extended ? IDX_W'(cf2a_pkg::EXT_ID_DIGITS)
                                : IDX_W'(cf2a_pkg::STD_ID_DIGITS);
    off     = char_idx - id_end - IDX_W'(1);
    k       = off - IDX_W'(3);
    nbytes  = (frame.data_length > 4'(MAX_PAYLOAD_BYTES)) ? 4'(MAX_PAYLOAD_BYTES)
                                                          : frame.data_length;
    pay_chars = IDX_W'({nbytes, 1'b0});
    nib_pos = 3'(id_end - char_idx);
    id_ext  = {3'b000, frame.can_id};
    pay_nib = k[3:0] ^ 4'h1;

    sel_item.last = 1'b0;
    if (char_idx == '0) begin
      sel_item.char_code = frame.is_extended ? cf2a_pkg::CHAR_EXT_HEADER
                                             : cf2a_pkg::CHAR_STD_HEADER;
    end else if (char_idx <= id_end) begin
      sel_item.char_code = cf2a_pkg::hex_char(id_ext[{nib_pos, 2'b00} +: 4]);
    end else if (off == IDX_W'(0)) begin
      sel_item.char_code = cf2a_pkg::hex_char(frame.filter_index[7:4]);
    end else if (off == IDX_W'(1)) begin
      sel_item.char_code = cf2a_pkg::hex_char(frame.filter_index[3:0]);
    end else if (off == IDX_W'(2)) begin
      sel_item.char_code = cf2a_pkg::hex_char(frame.data_length);
    end else if (k < pay_chars) begin
      sel_item.char_code = cf2a_pkg::hex_char(frame.payload[{pay_nib, 2'b00} +: 4]);
    end else begin
      sel_item.char_code = terminator;
      sel_item.last      = 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/can_frame_to_ascii_hex.sv
`default_nettype none
// ----------------------------------------------------------------------------
// can_frame_to_ascii_hex
// Turns one received CAN frame into its ASCII hex text line, one character
// per request on the output channel.
// ----------------------------------------------------------------------------
//  Channel     Direction  Handshake                     Payload
//  frame       in         frame_valid / frame_stall     frame_item (frame_t)
//  text        out        text_valid / text_stall       text_item (text_t)
//  terminator  in         terminator_we                 terminator_wdata
//
// A frame's line has 8 + 2n characters (standard) or 13 + 2n (extended), n being
// the printed payload byte count, so 8 to 29 characters; the output register
// issues one character per cycle while the output is not stalled. The next
// frame is taken in the cycle that issues the terminator. Reset clears the busy
// flag, the character counter and text_valid and sets the terminator to carriage
// return. A stall on the output holds the character counter and, once busy, the input.
module can_frame_to_ascii_hex #(
  parameter int unsigned MAX_PAYLOAD_BYTES = cf2a_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              frame_valid,
  output logic              frame_stall,
  input  cf2a_pkg::frame_t  frame_item,
  output logic              text_valid,
  input  logic              text_stall,
  output cf2a_pkg::text_t   text_item,
  input  logic              terminator_we,
  input  logic [7:0]        terminator_wdata
);

  localparam int unsigned MAX_CHARS = 13 + 2 * MAX_PAYLOAD_BYTES;
  localparam int unsigned IDX_W     = $clog2(MAX_CHARS);

  cf2a_pkg::frame_t  frame;
  logic              busy;
  logic [IDX_W-1:0]  char_idx;
  logic [7:0]        terminator;
  cf2a_pkg::text_t   sel_item;
  logic              out_load;
  logic              frame_take;

  cf2a_char_sel #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
    .IDX_W             (IDX_W)
  ) u_char_sel (
    .frame      (frame),
    .char_idx   (char_idx),
    .terminator (terminator),
    .sel_item   (sel_item)
  );

  assign out_load    = busy && (!text_valid || !text_stall);
  assign frame_stall = busy && !(out_load && sel_item.last);
  assign frame_take  = frame_valid && !frame_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      terminator <= cf2a_pkg::TERMINATOR_RESET;
    end else if (terminator_we) begin
      terminator <= terminator_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      char_idx <= '0;
    end else begin
      if (frame_take) begin
        busy     <= 1'b1;
        char_idx <= '0;
      end else if (out_load) begin
        if (sel_item.last) begin
          busy     <= 1'b0;
          char_idx <= '0;
        end else begin
          char_idx <= char_idx + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      frame <= frame_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (out_load) begin
      text_valid <= 1'b1;
    end else if (!text_stall) begin
      text_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      text_item <= sel_item;
    end
  end

  a_idle_idx_zero: assert property (@(posedge clk) disable iff (rst)
    !busy |-> char_idx == '0)
    else $error("character counter not cleared while idle");

  a_take_when_done: assert property (@(posedge clk) disable iff (rst)
    (frame_take && busy) |-> (out_load && sel_item.last))
    else $error("new frame taken before the terminator was issued");

  a_busy_ends_last: assert property (@(posedge clk) disable iff (rst)
    (busy && !frame_take && out_load && sel_item.last) |=> (!busy && text_item.last))
    else $error("frame ended without a terminator in the output register");

endmodule
`default_nettype wire

FILE: verif/can_frame_to_ascii_hex_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// can_frame_to_ascii_hex_tb
// Drives CAN frames into the encoder and checks every ASCII character that
// comes out against a line predicted from the frame and the terminator
// setting, with random idling on both channels and several terminators.
// ----------------------------------------------------------------------------
module can_frame_to_ascii_hex_tb;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned IDLE_PERCENT   = 31;

  class ascii_line_tracker;
    cf2a_pkg::text_t pending_chars[$];
    logic [7:0]      terminator;
    int              errors;

    function new();
      terminator = cf2a_pkg::TERMINATOR_RESET;
      errors     = 0;
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction

    function void add_char(logic [7:0] code, logic fin);
      cf2a_pkg::text_t t;
      t.char_code = code;
      t.last      = fin;
      pending_chars.push_back(t);
    endfunction

    function void add_hex(logic [3:0] nib);
      if (nib < 4'd10) begin
        add_char("0" + {4'h0, nib}, 1'b0);
      end else begin
        add_char("a" + {4'h0, nib} - 8'd10, 1'b0);
      end
    endfunction

    // Predicts the whole text line for one accepted frame request.
    function void note_frame(cf2a_pkg::frame_t f);
      logic [31:0] id_word;
      int          n_digits;
      int          n_bytes;
      int          k;
      if (f.is_extended) begin
        add_char(cf2a_pkg::CHAR_EXT_HEADER, 1'b0);
        id_word  = {3'b000, f.can_id};
        n_digits = cf2a_pkg::EXT_ID_DIGITS;
      end else begin
        add_char(cf2a_pkg::CHAR_STD_HEADER, 1'b0);
        id_word  = {20'h00000, f.can_id[11:0]};
        n_digits = cf2a_pkg::STD_ID_DIGITS;
      end
      for (k = n_digits; k > 0; k--) begin
        add_hex(id_word[4*k-1 -: 4]);
      end
      add_hex(f.filter_index[7:4]);
      add_hex(f.filter_index[3:0]);
      add_hex(f.data_length);
      n_bytes = (f.data_length > cf2a_pkg::MAX_PAYLOAD_BYTES_DEF)
                ? int'(cf2a_pkg::MAX_PAYLOAD_BYTES_DEF) : int'(f.data_length);
      for (k = 0; k < n_bytes; k++) begin
        add_hex(f.payload[8*k+4 +: 4]);
        add_hex(f.payload[8*k +: 4]);
      end
      add_char(terminator, 1'b1);
    endfunction

    function void check_char(cf2a_pkg::text_t got);
      cf2a_pkg::text_t want;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character, got char_code %h last %b",
                 $time, got.char_code, got.last);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      if (got.char_code !== want.char_code) begin
        $display("%0t: char_code mismatch, expected %h, got %h",
                 $time, want.char_code, got.char_code);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch, expected %b, got %b",
                 $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             frame_valid = 1'b0;
  logic             frame_stall;
  cf2a_pkg::frame_t frame_item = '0;
  logic             text_valid;
  logic             text_stall = 1'b0;
  cf2a_pkg::text_t  text_item;
  logic             terminator_we = 1'b0;
  logic [7:0]       terminator_wdata = 8'h00;

  ascii_line_tracker line_book = new();
  bit                steady_flow = 1'b0;
  int unsigned       stalled_cycles = 0;

  can_frame_to_ascii_hex u_dut (
    .clk              (clk),
    .rst              (rst),
    .frame_valid      (frame_valid),
    .frame_stall      (frame_stall),
    .frame_item       (frame_item),
    .text_valid       (text_valid),
    .text_stall       (text_stall),
    .text_item        (text_item),
    .terminator_we    (terminator_we),
    .terminator_wdata (terminator_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (text_valid === 1'b1 && !text_stall) begin
        line_book.check_char(text_item);
      end
      text_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    if (rst || (frame_valid && !frame_stall) || (text_valid === 1'b1 && !text_stall)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles == WATCHDOG_LIMIT) begin
      $display("can_frame_to_ascii_hex_tb: done, errors");
      $finish;
    end
  end

  function automatic cf2a_pkg::frame_t frame_of(logic ext, logic [28:0] id,
                                                logic [7:0] filt, logic [3:0] len,
                                                logic [63:0] data);
    cf2a_pkg::frame_t f;
    f.is_extended  = ext;
    f.can_id       = id;
    f.filter_index = filt;
    f.data_length  = len;
    f.payload      = data;
    return f;
  endfunction

  function automatic cf2a_pkg::frame_t random_frame();
    logic [28:0] id;
    logic [3:0]  len;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      id = '0;
    end else if (pick == 1) begin
      id = '1;
    end else begin
      id = 29'($urandom);
    end
    if ($urandom_range(0, 99) < 85) begin
      len = 4'($urandom_range(0, 8));
    end else begin
      len = 4'($urandom_range(9, 15));
    end
    return frame_of(1'($urandom_range(0, 1)), id, 8'($urandom), len,
                    {$urandom, $urandom});
  endfunction

  task automatic send_frame(cf2a_pkg::frame_t f);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
      frame_valid <= 1'b0;
      @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame_item  <= f;
    do @(posedge clk); while (frame_stall);
    line_book.note_frame(f);
  endtask

  task automatic set_terminator(logic [7:0] value);
    frame_valid <= 1'b0;
    while (line_book.pending() != 0) @(posedge clk);
    terminator_we    <= 1'b1;
    terminator_wdata <= value;
    @(posedge clk);
    terminator_we       <= 1'b0;
    line_book.terminator = value;
  endtask

  task automatic send_random(int count);
    int n;
    for (n = 0; n < count; n++) begin
      send_frame(random_frame());
    end
  endtask

  initial begin
    int len;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_frame(frame_of(1'b0, 29'h0, 8'h00, 4'd0, 64'h0));
    send_frame(frame_of(1'b1, 29'h0, 8'h00, 4'd0, 64'h0));
    send_frame(frame_of(1'b0, '1, 8'hFF, 4'd8, '1));
    send_frame(frame_of(1'b1, '1, 8'hFF, 4'd8, '1));

    set_terminator(8'h00);
    send_frame(frame_of(1'b0, 29'h1ABCD123, 8'h5A, 4'd3, 64'h0000_0000_00C3_7E81));
    send_frame(frame_of(1'b1, 29'h10000000, 8'h80, 4'd1, 64'hFFFF_FFFF_FFFF_FFA5));
    send_frame(frame_of(1'b1, 29'h0ABCDEF1, 8'h01, 4'd9, 64'h0123_4567_89AB_CDEF));
    send_frame(frame_of(1'b0, 29'h00000FFF, 8'h10, 4'd15, 64'hFEDC_BA98_7654_3210));
    send_frame(frame_of(1'b0, 29'h00000800, 8'hA5, 4'd7, 64'h5555_5555_5555_5555));
    send_frame(frame_of(1'b1, 29'h15555555, 8'h3C, 4'd8, 64'hAAAA_AAAA_AAAA_AAAA));
    send_frame(frame_of(1'b0, 29'h0AAAA7FF, 8'hC3, 4'd2, 64'h0000_0000_0000_9F60));
    for (len = 1; len < 16; len += 2) begin
      send_frame(frame_of(1'($urandom_range(0, 1)), 29'($urandom), 8'($urandom),
                          len[3:0], {$urandom, $urandom}));
    end

    set_terminator(8'hFF);
    send_random(55);
    set_terminator(8'($urandom_range(0, 255)));
    send_random(55);
    set_terminator(8'h0A);
    steady_flow = 1'b1;
    send_random(40);
    steady_flow = 1'b0;
    send_random(15);
    set_terminator(cf2a_pkg::TERMINATOR_RESET);
    send_random(55);

    frame_valid <= 1'b0;
    while (line_book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (line_book.pending() != 0) begin
      $display("%0t: %0d expected characters never arrived", $time, line_book.pending());
      line_book.errors++;
    end
    if (line_book.errors == 0) begin
      $display("can_frame_to_ascii_hex_tb: done, clean");
    end else begin
      $display("can_frame_to_ascii_hex_tb: done, errors");
    end
    $finish;
  end

endmodule
